### hw/rtl/hcpm_pkg.sv
//------------------------------------------------------------------------------
// hcpm_pkg
// Types and constants shared by the peripheral map front and back ends.
//------------------------------------------------------------------------------
`default_nettype none

package hcpm_pkg;

   localparam int unsigned CmdWidth  = 3;
   localparam int unsigned AddrWidth = 16;

   typedef enum logic [CmdWidth-1:0] {
      CMD_READ    = 3'd0,
      CMD_WRITE   = 3'd1,
      CMD_KEY_ROW = 3'd2,
      CMD_MODS    = 3'd3,
      CMD_ROM     = 3'd4
   } cmd_type;

   // Decoded bus addresses
   localparam logic [15:0] AddrRomBase  = 16'hF800;
   localparam logic [15:0] AddrCrtCmd   = 16'hC001;
   localparam logic [15:0] AddrCrtData  = 16'hC000;
   localparam logic [15:0] AddrKeyLatch = 16'h8000;
   localparam logic [15:0] AddrKeyIn    = 16'h8001;
   localparam logic [15:0] AddrMods     = 16'h8002;
   localparam logic [15:0] AddrDmaMode  = 16'hE008;
   localparam logic [15:0] AddrDmaAddr  = 16'hE004;
   localparam logic [15:0] AddrDmaCount = 16'hE005;
   localparam logic [15:0] MirrorMask   = 16'hEFFF;
   localparam logic [15:0] RomMask      = 16'h07FF;

   localparam logic [7:0] DataCursor   = 8'h80;
   localparam logic [7:0] DataFormat   = 8'h00;
   localparam logic [7:0] DataDmaReset = 8'h80;
   localparam logic [7:0] DataDmaStart = 8'hA4;

   // Classified item handed from front end to back end
   typedef struct packed {
      cmd_type                cmd;
      logic [AddrWidth-1:0]   addr;
      logic [7:0]             data;
      logic [2:0]             key_row;
   } item_type;

   // Result item
   typedef struct packed {
      logic [15:0] screen_base;
      logic [6:0]  visible_rows;
      logic [7:0]  screen_columns;
      logic        screen_restarted;
      logic [7:0]  draw_code;
      logic [6:0]  draw_row;
      logic [7:0]  draw_column;
      logic        draw_valid;
      logic [7:0]  read_data;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEM,
      ST_DIV,
      ST_DONE,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/home_computer_peripheral_map.sv
// Each item passes through ST_IDLE, ST_MEM, ST_DIV, ST_DONE and ST_OUT; a write
// that needs the serial divide (window position or row clamp) waits in ST_DONE
// for its 16 steps. The back end takes one item at a time; the front register
// and queue hold up to three items meanwhile.
// Reset: synchronous, active high; clears keyboard rows, modifiers and
// window state. RAM and ROM contents are undefined until written.
//------------------------------------------------------------------------------
// home_computer_peripheral_map
// Memory-mapped peripherals of a small home computer: ROM, RAM, keyboard,
// display controller and DMA byte catchers.
//------------------------------------------------------------------------------
`default_nettype none

module home_computer_peripheral_map #(
   parameter int unsigned ROM_DEPTH     = 2048,
   parameter int unsigned KEY_ROWS      = 8,
   parameter int unsigned COLUMN_OFFSET = 8,
   parameter int unsigned ROW_OFFSET    = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[2:0], address[18:3], data[26:19], key_row[29:27], zero[31:30]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[7:0], draw_valid[8], draw_column[16:9], draw_row[23:17],
   // draw_code[31:24], screen_restarted[32], screen_columns[40:33],
   // visible_rows[47:41], screen_base[63:48]
   output logic [63:0]      rsp_tdata
);
   import hcpm_pkg::*;

   item_type   f_item, q_item;
   logic       f_valid, f_ready, q_valid, q_ready;
   result_type res;

   hcpm_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
   );

   hcpm_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   hcpm_back #(
      .ROM_DEPTH(ROM_DEPTH), .KEY_ROWS(KEY_ROWS),
      .COLUMN_OFFSET(COLUMN_OFFSET), .ROW_OFFSET(ROW_OFFSET)
   ) u_back (
      .clock, .reset,
      .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(res)
   );

   assign rsp_tdata = res;

endmodule

`default_nettype wire

### hw/rtl/hcpm_queue.sv
//------------------------------------------------------------------------------
// hcpm_queue
// Two-entry item queue between the front end and the back end.
//------------------------------------------------------------------------------
`default_nettype none

module hcpm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire hcpm_pkg::item_type in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output hcpm_pkg::item_type      out_item
);
   import hcpm_pkg::*;

   item_type   slot_ff [2];
   item_type   slot_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      slot_in   = in_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/hcpm_front.sv
//------------------------------------------------------------------------------
// hcpm_front
// Accepts request items, unpacks the fields and registers them for the queue.
//------------------------------------------------------------------------------
`default_nettype none

module hcpm_front (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,
   output logic               item_valid,
   input  wire logic          item_ready,
   output hcpm_pkg::item_type item
);
   import hcpm_pkg::*;

   item_type item_ff, item_in;
   logic     valid_ff, valid_in;

   assign req_tready = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   // unpack: command[2:0], address[18:3], data[26:19], key_row[29:27]
   always_comb begin
      item_in.cmd     = cmd_type'(req_tdata[2:0]);
      item_in.addr    = req_tdata[18:3];
      item_in.data    = req_tdata[26:19];
      item_in.key_row = req_tdata[29:27];
      valid_in        = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/hcpm_back.sv
//------------------------------------------------------------------------------
// hcpm_back
// Executes one item: memories, keyboard, write catchers and draw position.
//------------------------------------------------------------------------------
`default_nettype none

module hcpm_back #(
   parameter int unsigned ROM_DEPTH     = 2048,
   parameter int unsigned KEY_ROWS      = 8,
   parameter int unsigned COLUMN_OFFSET = 8,
   parameter int unsigned ROW_OFFSET    = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   output logic                    item_ready,
   input  wire hcpm_pkg::item_type item,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output hcpm_pkg::result_type    rsp
);
   import hcpm_pkg::*;

   // ROM_DEPTH is a power of two; the ROM index is the low address bits
   localparam int unsigned RomAw = $clog2(ROM_DEPTH);
   localparam int unsigned RowW  = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;

   // memories
   logic [7:0] ram_mem [65536];
   logic [7:0] rom_mem [ROM_DEPTH];
   logic [7:0] ram_q_ff, rom_q_ff, latch_ff;
   logic [RomAw-1:0] rom_rd_idx, rom_wr_idx;

   state_type  state_ff, state_in;
   item_type   cur_ff;
   result_type res_ff, res_in;

   logic [7:0]  key_ff [KEY_ROWS];
   logic [7:0]  mods_ff;
   logic [1:0]  cur_seq_ff, fmt_seq_ff;
   logic [2:0]  dma_seq_ff;
   logic [7:0]  pcols_ff;
   logic [6:0]  prows_ff;
   logic [15:0] dbase_ff;
   logic [14:0] dlen_ff;
   logic [7:0]  wcols_ff;
   logic [6:0]  wrows_ff;
   logic [15:0] wbase_ff;
   logic [13:0] wsize_ff;

   // serial divider: quotient/remainder of a 16 bit dividend by an 8 bit divisor
   logic [15:0] dq_ff;
   logic [8:0]  drem_ff;
   logic [7:0]  ddiv_ff;
   logic [4:0]  dcnt_ff;
   logic        div_busy;
   logic [8:0]  trial;
   logic [9:0]  diff;
   logic        is_draw_ff;  // divide is a draw rather than a clamp

   logic [15:0] m_addr;
   logic [7:0]  kb;
   logic [16:0] win_end;
   logic        in_win;
   logic [15:0] off;
   logic        chan_start, apply_start;
   logic [6:0]  fit_rows;

   assign item_ready = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_OUT);
   assign rsp        = res_ff;
   assign m_addr     = cur_ff.addr & MirrorMask;
   assign div_busy   = (dcnt_ff != 5'd0);
   assign win_end    = {1'b0, wbase_ff} + {3'b0, wsize_ff};
   assign in_win     = (cur_ff.addr >= wbase_ff) && ({1'b0, cur_ff.addr} < win_end);
   assign off        = cur_ff.addr - wbase_ff;
   assign rom_rd_idx = RomAw'(item.addr & RomMask);
   assign rom_wr_idx = RomAw'(cur_ff.addr);

   // channel start and the row count after the clamp
   assign chan_start  = (cur_ff.cmd == CMD_WRITE) && (m_addr == AddrDmaMode) &&
                        (cur_ff.data == DataDmaStart) && (pcols_ff != 8'd0) &&
                        (prows_ff != 7'd0);
   assign apply_start = (state_ff == ST_DONE) && !div_busy && !is_draw_ff && chan_start;
   assign fit_rows    = ({9'd0, prows_ff} > dq_ff) ? dq_ff[6:0] : prows_ff;

   // keyboard AND over selected rows
   always_comb begin
      kb = 8'hFF;
      for (int i = 0; i < KEY_ROWS; i++) begin
         if (!latch_ff[i]) kb = kb & key_ff[i];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (item_valid) state_in = ST_MEM;
         ST_MEM:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_DONE;
         ST_DONE: if (!div_busy) state_in = ST_OUT;
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // divider step
   always_comb begin
      trial = {drem_ff[7:0], dq_ff[15]};
      diff  = {1'b0, trial} - {2'b0, ddiv_ff};
   end

   // output fields
   always_comb begin
      res_in = res_ff;
      if (state_ff == ST_MEM) begin
         res_in = '0;
         if (cur_ff.cmd == CMD_READ) begin
            if (cur_ff.addr >= AddrRomBase)   res_in.read_data = rom_q_ff;
            else if (cur_ff.addr == AddrCrtCmd) res_in.read_data = 8'hFF;
            else if (cur_ff.addr == AddrMods) res_in.read_data = mods_ff;
            else if (cur_ff.addr == AddrKeyIn) res_in.read_data = kb;
            else res_in.read_data = ram_q_ff;
         end
      end
      if (state_ff == ST_DONE && !div_busy) begin
         if (is_draw_ff && cur_ff.cmd == CMD_WRITE && !res_ff.screen_restarted) begin
            res_in.draw_valid  = 1'b1;
            res_in.draw_code   = cur_ff.data;
            res_in.draw_column = drem_ff[7:0] - 8'(COLUMN_OFFSET);
            res_in.draw_row    = dq_ff[6:0] - 7'(ROW_OFFSET);
         end
         // a channel start reports the window it opens
         res_in.screen_restarted = apply_start;
         res_in.screen_columns   = apply_start ? pcols_ff : wcols_ff;
         res_in.visible_rows     = apply_start ? fit_rows : wrows_ff;
         res_in.screen_base      = apply_start ? dbase_ff : wbase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mods_ff    <= 8'hFF;
         cur_seq_ff <= 2'd0;
         fmt_seq_ff <= 2'd0;
         dma_seq_ff <= 3'd0;
         pcols_ff   <= 8'd0;
         prows_ff   <= 7'd0;
         dbase_ff   <= 16'd0;
         dlen_ff    <= 15'd0;
         wcols_ff   <= 8'd0;
         wrows_ff   <= 7'd0;
         wbase_ff   <= 16'd0;
         wsize_ff   <= 14'd0;
         dcnt_ff    <= 5'd0;
         is_draw_ff <= 1'b0;
         for (int i = 0; i < KEY_ROWS; i++) key_ff[i] <= 8'hFF;
      end else begin
         state_ff <= state_in;
         // key and modifier updates
         if (state_ff == ST_MEM && cur_ff.cmd == CMD_KEY_ROW &&
             {5'd0, cur_ff.key_row} < 8'(KEY_ROWS)) begin
            key_ff[cur_ff.key_row[RowW-1:0]] <= cur_ff.data;
         end
         if (state_ff == ST_MEM && cur_ff.cmd == CMD_MODS) mods_ff <= cur_ff.data;
         // write catchers, applied once per write
         if (state_ff == ST_MEM && cur_ff.cmd == CMD_WRITE) begin
            is_draw_ff <= 1'b0;
            if (m_addr == AddrCrtCmd && cur_ff.data == DataCursor) begin
               cur_seq_ff <= 2'd1;
            end else if (m_addr == AddrCrtData && cur_seq_ff == 2'd1) begin
               cur_seq_ff <= 2'd2;
            end else if (m_addr == AddrCrtData && cur_seq_ff == 2'd2) begin
               cur_seq_ff <= 2'd0;
            end else if (m_addr == AddrCrtCmd && cur_ff.data == DataFormat) begin
               fmt_seq_ff <= 2'd1;
            end else if (m_addr == AddrCrtData && fmt_seq_ff == 2'd1) begin
               pcols_ff   <= {1'b0, cur_ff.data[6:0]} + 8'd1;
               fmt_seq_ff <= 2'd2;
            end else begin
               if (m_addr == AddrCrtData && fmt_seq_ff == 2'd2) begin
                  prows_ff   <= {1'b0, cur_ff.data[5:0]} + 7'd1;
                  fmt_seq_ff <= 2'd0;
               end
               if (m_addr == AddrDmaMode && cur_ff.data == DataDmaReset) begin
                  dma_seq_ff <= 3'd1;
               end else if (m_addr == AddrDmaAddr && dma_seq_ff == 3'd1) begin
                  dbase_ff   <= {8'd0, cur_ff.data};
                  dma_seq_ff <= 3'd2;
               end else if (m_addr == AddrDmaAddr && dma_seq_ff == 3'd2) begin
                  dbase_ff[15:8] <= cur_ff.data;
                  dma_seq_ff     <= 3'd3;
               end else if (m_addr == AddrDmaCount && dma_seq_ff == 3'd3) begin
                  dlen_ff    <= {7'd0, cur_ff.data};
                  dma_seq_ff <= 3'd4;
               end else begin
                  if (m_addr == AddrDmaCount && dma_seq_ff == 3'd4) begin
                     dlen_ff <= {1'b0, cur_ff.data[5:0], dlen_ff[7:0]} + 15'd1;
                     dma_seq_ff <= 3'd0;
                  end
                  // channel start or window check, settled in ST_DIV
                  is_draw_ff <= 1'b1;
               end
            end
         end
         // ST_DIV: channel start needs dlen / pcols, draw needs off / wcols
         if (state_ff == ST_DIV && cur_ff.cmd == CMD_WRITE && is_draw_ff &&
             dcnt_ff == 5'd0) begin
            if (chan_start) begin
               dq_ff      <= {1'b0, dlen_ff};
               ddiv_ff    <= pcols_ff;
               drem_ff    <= 9'd0;
               dcnt_ff    <= 5'd16;
               is_draw_ff <= 1'b0;
            end else if (wcols_ff != 8'd0 && in_win) begin
               dq_ff   <= off;
               ddiv_ff <= wcols_ff;
               drem_ff <= 9'd0;
               dcnt_ff <= 5'd16;
            end else begin
               is_draw_ff <= 1'b0;
            end
         end else if (div_busy) begin
            dcnt_ff <= dcnt_ff - 5'd1;
            if (!diff[9]) begin
               drem_ff <= diff[8:0];
               dq_ff   <= {dq_ff[14:0], 1'b1};
            end else begin
               drem_ff <= trial;
               dq_ff   <= {dq_ff[14:0], 1'b0};
            end
         end
         // apply a channel start once the clamp quotient is ready
         if (apply_start) begin
            wcols_ff <= pcols_ff;
            wbase_ff <= dbase_ff;
            prows_ff <= fit_rows;
            wrows_ff <= fit_rows;
            wsize_ff <= {6'd0, pcols_ff} * {7'd0, fit_rows};
         end
      end
   end

   // current item and result registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && item_valid) cur_ff <= item;
      if (state_ff == ST_MEM || (state_ff == ST_DONE && !div_busy)) res_ff <= res_in;
   end

   // memory ports: read in ST_IDLE capture, write in ST_MEM
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && item_valid) begin
         ram_q_ff <= ram_mem[item.addr];
         rom_q_ff <= rom_mem[rom_rd_idx];
         latch_ff <= ram_mem[AddrKeyLatch];
      end
      if (state_ff == ST_MEM && cur_ff.cmd == CMD_WRITE) ram_mem[cur_ff.addr] <= cur_ff.data;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MEM && cur_ff.cmd == CMD_ROM) begin
         rom_mem[rom_wr_idx] <= cur_ff.data;
      end
   end

endmodule

`default_nettype wire
